// File: hw/rtl/tte_pkg.sv
// Shared constants, types and a lookup function for the timestamp text to epoch block.
package tte_pkg;

    localparam int CHAR_W  = 8;
    localparam int YEAR_W  = 14;
    localparam int FIELD_W = 7;
    localparam int POS_W   = 5;
    localparam int EPOCH_W = 39;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIME    = 2'd2;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic               len_date;
        logic               len_time;
        logic               text_ok;
    } t_fields;

    // days before the first of the month; months outside 1..12 give 0
    function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] month);
        logic [8:0] d;
        begin
            case (month)
                4'd1:    d = 9'd0;
                4'd2:    d = 9'd31;
                4'd3:    d = leap ? 9'd60  : 9'd59;
                4'd4:    d = leap ? 9'd91  : 9'd90;
                4'd5:    d = leap ? 9'd121 : 9'd120;
                4'd6:    d = leap ? 9'd152 : 9'd151;
                4'd7:    d = leap ? 9'd182 : 9'd181;
                4'd8:    d = leap ? 9'd213 : 9'd212;
                4'd9:    d = leap ? 9'd244 : 9'd243;
                4'd10:   d = leap ? 9'd274 : 9'd273;
                4'd11:   d = leap ? 9'd305 : 9'd304;
                4'd12:   d = leap ? 9'd335 : 9'd334;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

endpackage

// File: hw/rtl/tte_if.sv
// Valid/ready channel interfaces for character input and epoch result words.
interface tte_char_if;
    logic                       valid;
    logic                       ready;
    logic [tte_pkg::CHAR_W-1:0] char_code;
    logic                       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface tte_epoch_if;
    logic                               valid;
    logic                               ready;
    logic signed [tte_pkg::EPOCH_W-1:0] epoch_seconds;
    logic [tte_pkg::KIND_W-1:0]         format_kind;

    modport source (output valid, output epoch_seconds, output format_kind, input ready);
    modport sink   (input valid, input epoch_seconds, input format_kind, output ready);
endinterface

// File: hw/rtl/tte_parse.sv
// Character parser: checks format, accumulates date/time fields, hands off on end of text.
module tte_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tte_char_if.sink         i_char,
    output logic             o_valid,
    output tte_pkg::t_fields o_fields,
    input  logic             i_ready
);
    import tte_pkg::*;

    localparam logic [POS_W-1:0]  POS_YEAR_END  = 5'd3;
    localparam logic [POS_W-1:0]  POS_MONTH_END = 5'd6;
    localparam logic [POS_W-1:0]  POS_DAY_END   = 5'd9;
    localparam logic [POS_W-1:0]  POS_HOUR_END  = 5'd12;
    localparam logic [POS_W-1:0]  POS_MIN_END   = 5'd15;
    localparam logic [POS_W-1:0]  POS_LAST      = 5'd19;
    localparam logic [POS_W-1:0]  POS_SAT       = 5'd20;
    localparam logic [POS_W-1:0]  LEN_DATE      = 5'd10;
    localparam logic [POS_W-1:0]  LEN_TIME      = 5'd19;
    localparam logic [CHAR_W-1:0] CHAR_NONE     = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SLASH    = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_COLON    = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'h39;

    function automatic logic [CHAR_W-1:0] sep_at(input logic [POS_W-1:0] p);
        logic [CHAR_W-1:0] s;
        begin
            case (p)
                5'd4, 5'd7:   s = CHAR_SLASH;
                5'd10:        s = CHAR_SPACE;
                5'd13, 5'd16: s = CHAR_COLON;
                default:      s = CHAR_NONE;
            endcase
            return s;
        end
    endfunction

    function automatic logic [FIELD_W-1:0] acc2(input logic [FIELD_W-1:0] v,
                                                input logic [3:0] d);
        return FIELD_W'(v * FIELD_W'(10) + FIELD_W'(d));
    endfunction

    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [YEAR_W-1:0]  r_year,   n_year;
    logic [FIELD_W-1:0] r_month,  n_month;
    logic [FIELD_W-1:0] r_day,    n_day;
    logic [FIELD_W-1:0] r_hour,   n_hour;
    logic [FIELD_W-1:0] r_minute, n_minute;
    logic [FIELD_W-1:0] r_second, n_second;
    logic               r_ok,     n_ok;
    logic               r_valid;
    t_fields            r_fields;

    logic [CHAR_W-1:0]  sep;
    logic [3:0]         digit;
    logic               accept;

    assign i_char.ready = !r_valid || i_ready;
    assign accept       = i_char.valid && i_char.ready;
    assign o_valid      = r_valid;
    assign o_fields     = r_fields;

    always_comb begin
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_ok     = r_ok;
        sep      = sep_at(r_pos);
        digit    = i_char.char_code[3:0];
        if (r_pos >= POS_LAST) begin
            n_ok = 1'b0;
        end else if (sep != CHAR_NONE) begin
            if (i_char.char_code != sep) begin
                n_ok = 1'b0;
            end
        end else if (!(i_char.char_code inside {[CHAR_ZERO:CHAR_NINE]})) begin
            n_ok = 1'b0;
        end else if (r_pos <= POS_YEAR_END) begin
            n_year = YEAR_W'(r_year * YEAR_W'(10) + YEAR_W'(digit));
        end else if (r_pos <= POS_MONTH_END) begin
            n_month = acc2(r_month, digit);
        end else if (r_pos <= POS_DAY_END) begin
            n_day = acc2(r_day, digit);
        end else if (r_pos <= POS_HOUR_END) begin
            n_hour = acc2(r_hour, digit);
        end else if (r_pos <= POS_MIN_END) begin
            n_minute = acc2(r_minute, digit);
        end else begin
            n_second = acc2(r_second, digit);
        end
        n_pos = (r_pos < POS_SAT) ? r_pos + POS_W'(1) : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_ok     <= 1'b1;
            r_valid  <= 1'b0;
        end else begin
            if (i_char.ready) begin
                r_valid <= accept && i_char.end_of_text;
            end
            if (accept && i_char.end_of_text) begin
                r_pos    <= '0;
                r_year   <= '0;
                r_month  <= '0;
                r_day    <= '0;
                r_hour   <= '0;
                r_minute <= '0;
                r_second <= '0;
                r_ok     <= 1'b1;
            end else if (accept) begin
                r_pos    <= n_pos;
                r_year   <= n_year;
                r_month  <= n_month;
                r_day    <= n_day;
                r_hour   <= n_hour;
                r_minute <= n_minute;
                r_second <= n_second;
                r_ok     <= n_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_char.end_of_text) begin
            r_fields.year     <= n_year;
            r_fields.month    <= n_month;
            r_fields.day      <= n_day;
            r_fields.hour     <= n_hour;
            r_fields.minute   <= n_minute;
            r_fields.second   <= n_second;
            r_fields.len_date <= (n_pos == LEN_DATE);
            r_fields.len_time <= (n_pos == LEN_TIME);
            r_fields.text_ok  <= n_ok;
        end
    end

endmodule

// File: hw/rtl/tte_calc.sv
// Epoch arithmetic pipeline: range checks, leap/century terms, day and second totals.
module tte_calc (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tte_pkg::t_fields i_fields,
    output logic             o_ready,
    tte_epoch_if.source      o_epoch
);
    import tte_pkg::*;

    localparam int SOD_W  = 19;
    localparam int DAYS_W = 16;
    localparam int PD_W   = 34;
    localparam int PY_W   = 40;
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SH  = 19;

    // stage 2: checks, offsets, quotients by reciprocal
    logic                    r_s2_v;
    logic [KIND_W-1:0]       r_s2_kind;
    logic [YEAR_W-1:0]       r_s2_year;
    logic [3:0]              r_s2_month;
    logic [FIELD_W-1:0]      r_s2_day;
    logic signed [15:0]      r_s2_ty;
    logic signed [15:0]      r_s2_q4;
    logic [7:0]              r_s2_q100;
    logic                    r_s2_neg100;
    logic [5:0]              r_s2_q400;
    logic                    r_s2_neg400;
    logic [7:0]              r_s2_qy;
    logic [SOD_W-1:0]        r_s2_sod;

    // stage 3: day count
    logic                     r_s3_v;
    logic [KIND_W-1:0]        r_s3_kind;
    logic signed [DAYS_W-1:0] r_s3_days;
    logic signed [15:0]       r_s3_ty70;
    logic [SOD_W-1:0]         r_s3_sod;

    // stage 4: products
    logic                    r_s4_v;
    logic [KIND_W-1:0]       r_s4_kind;
    logic signed [PD_W-1:0]  r_s4_pd;
    logic signed [PY_W-1:0]  r_s4_py;
    logic [SOD_W-1:0]        r_s4_sod;

    // stage 5: output word
    logic                      r_s5_v;
    logic [KIND_W-1:0]         r_s5_kind;
    logic signed [EPOCH_W-1:0] r_s5_epoch;

    logic rdy2, rdy3, rdy4, rdy5;

    assign rdy5    = !r_s5_v || o_epoch.ready;
    assign rdy4    = !r_s4_v || rdy5;
    assign rdy3    = !r_s3_v || rdy4;
    assign rdy2    = !r_s2_v || rdy3;
    assign o_ready = rdy2;

    assign o_epoch.valid         = r_s5_v;
    assign o_epoch.epoch_seconds = r_s5_epoch;
    assign o_epoch.format_kind   = r_s5_kind;

    // stage 2 logic
    logic               ok;
    logic [KIND_W-1:0]  kind;
    logic signed [15:0] ty, a4, a100, a400, q4;
    logic [14:0]        m100;
    logic [12:0]        m400;
    logic [27:0]        p100, py;
    logic [25:0]        p400;
    logic [SOD_W-1:0]   sod;

    always_comb begin
        ok = i_fields.text_ok && (i_fields.len_date || i_fields.len_time)
             && i_fields.month >= FIELD_W'(1) && i_fields.month <= FIELD_W'(12)
             && i_fields.day >= FIELD_W'(1) && i_fields.day <= FIELD_W'(31);
        if (i_fields.len_time) begin
            ok = ok && i_fields.hour <= FIELD_W'(23) && i_fields.minute <= FIELD_W'(59)
                 && i_fields.second <= FIELD_W'(59);
        end
        kind = ok ? (i_fields.len_time ? KIND_TIME : KIND_DATE) : KIND_INVALID;
        ty   = signed'({2'b00, i_fields.year}) - 16'sd1900;
        a4   = ty - 16'sd69;
        q4   = a4[15] ? -((-a4) >>> 2) : (a4 >>> 2);
        a100 = ty - 16'sd1;
        m100 = a100[15] ? 15'(-a100) : 15'(a100);
        a400 = ty + 16'sd299;
        m400 = a400[15] ? 13'((-a400) >>> 2) : 13'(a400 >>> 2);
        p100 = 28'(m100) * 28'(RECIP_100);
        p400 = 26'(m400) * 26'(RECIP_100);
        py   = 28'(i_fields.year) * 28'(RECIP_100);
        sod  = '0;
        if (i_fields.len_time) begin
            sod = SOD_W'(i_fields.second) + SOD_W'(i_fields.minute) * SOD_W'(60)
                  + SOD_W'(i_fields.hour) * SOD_W'(3600);
        end
    end

    // stage 3 logic
    logic [YEAR_W-1:0]        rem;
    logic                     leap;
    logic signed [DAYS_W-1:0] s100, s400, days;

    always_comb begin
        rem  = r_s2_year - YEAR_W'(r_s2_qy * YEAR_W'(100));
        leap = (r_s2_year[1:0] == 2'd0 && rem != '0) || (rem == '0 && r_s2_qy[1:0] == 2'd0);
        s100 = r_s2_neg100 ? -DAYS_W'(r_s2_q100) : DAYS_W'(r_s2_q100);
        s400 = r_s2_neg400 ? -DAYS_W'(r_s2_q400) : DAYS_W'(r_s2_q400);
        days = DAYS_W'(cum_days(leap, r_s2_month)) + DAYS_W'(r_s2_day) - 16'sd1
               + r_s2_q4 - s100 + s400;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            if (rdy2) r_s2_v <= i_valid;
            if (rdy3) r_s3_v <= r_s2_v;
            if (rdy4) r_s4_v <= r_s3_v;
            if (rdy5) r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_valid) begin
            r_s2_kind   <= kind;
            r_s2_year   <= i_fields.year;
            r_s2_month  <= i_fields.month[3:0];
            r_s2_day    <= i_fields.day;
            r_s2_ty     <= ty;
            r_s2_q4     <= q4;
            r_s2_q100   <= p100[RECIP_SH+7:RECIP_SH];
            r_s2_neg100 <= a100[15];
            r_s2_q400   <= p400[RECIP_SH+5:RECIP_SH];
            r_s2_neg400 <= a400[15];
            r_s2_qy     <= py[RECIP_SH+7:RECIP_SH];
            r_s2_sod    <= sod;
        end
        if (rdy3 && r_s2_v) begin
            r_s3_kind <= r_s2_kind;
            r_s3_days <= days;
            r_s3_ty70 <= r_s2_ty - 16'sd70;
            r_s3_sod  <= r_s2_sod;
        end
        if (rdy4 && r_s3_v) begin
            r_s4_kind <= r_s3_kind;
            r_s4_pd   <= PD_W'(r_s3_days) * 34'sd86400;
            r_s4_py   <= PY_W'(r_s3_ty70) * 40'sd31536000;
            r_s4_sod  <= r_s3_sod;
        end
        if (rdy5 && r_s4_v) begin
            r_s5_kind  <= r_s4_kind;
            r_s5_epoch <= (r_s4_kind == KIND_INVALID) ? '0
                          : EPOCH_W'(r_s4_py + PY_W'(r_s4_pd) + signed'(PY_W'(r_s4_sod)));
        end
    end

endmodule

// File: hw/rtl/timestamp_text_to_epoch.sv
// Top level: timestamp text to POSIX seconds converter.
//
// Input channel i_char carries one character word per handshake; end_of_text
// marks the last character. Texts "YYYY/MM/DD" and "YYYY/MM/DD HH:mm:ss" are
// accepted; any other text or length yields format_kind 0 and epoch 0.
// Output channel o_epoch carries one result word per text: signed 39-bit
// seconds since 1970-01-01 00:00:00 and the format kind (1 date, 2 date+time).
// Throughput: one character word per cycle, sustained while the receiver does not stall.
// The result word passes through the parser register and then four arithmetic
// stages: checks/reciprocal quotients, day total, constant products, sum.
// Characters without end_of_text produce no word and occupy no stage.
// When the receiver stalls, words pile into empty stages; input ready drops
// only once every stage holds a word.
// Reset (synchronous, active low) empties the pipeline and restarts parsing
// at the first character of a new text.
module timestamp_text_to_epoch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tte_char_if.sink    i_char,
    tte_epoch_if.source o_epoch
);
    import tte_pkg::*;

    logic    parse_valid;
    logic    calc_ready;
    t_fields parse_fields;

    tte_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (i_char),
        .o_valid  (parse_valid),
        .o_fields (parse_fields),
        .i_ready  (calc_ready)
    );

    tte_calc u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (parse_valid),
        .i_fields (parse_fields),
        .o_ready  (calc_ready),
        .o_epoch  (o_epoch)
    );

endmodule

// File: hw/rtl/tte_chk.sv
// Port-level checker for the timestamp text to epoch block, bound to the top level.
module tte_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [tte_pkg::EPOCH_W-1:0] i_epoch,
    input logic [tte_pkg::KIND_W-1:0]        i_kind
);
    import tte_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_epoch) && $stable(i_kind))
        else $error("result word dropped or changed while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind == KIND_INVALID || i_kind == KIND_DATE || i_kind == KIND_TIME))
        else $error("format kind out of range");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_INVALID |-> i_epoch == '0)
        else $error("invalid text with nonzero epoch");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word present after reset");

endmodule

bind timestamp_text_to_epoch tte_chk u_tte_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_epoch.valid),
    .i_out_ready (o_epoch.ready),
    .i_epoch     (o_epoch.epoch_seconds),
    .i_kind      (o_epoch.format_kind)
);
